### sv/source_token_scanner_top_macros.svh
// Assertion helpers for the token scanner
`ifndef SOURCE_TOKEN_SCANNER_TOP_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_TOP_MACROS_SVH

// Check a property at every clock edge outside reset
`define STSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge
`define STSC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### sv/stsc_pkg.sv
package stsc_pkg;

	localparam int NKW = 12;
	localparam int KW_MAX = 17;
	localparam int TOK_SLOTS = 4;
	localparam int QDEPTH = 4;
	localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

	// token kinds
	localparam logic [5:0] K_LPAREN = 6'd0;
	localparam logic [5:0] K_RPAREN = 6'd1;
	localparam logic [5:0] K_LBRACE = 6'd2;
	localparam logic [5:0] K_RBRACE = 6'd3;
	localparam logic [5:0] K_COMMA = 6'd4;
	localparam logic [5:0] K_DOT = 6'd5;
	localparam logic [5:0] K_MINUS = 6'd6;
	localparam logic [5:0] K_PLUS = 6'd7;
	localparam logic [5:0] K_SEMI = 6'd8;
	localparam logic [5:0] K_COLON = 6'd9;
	localparam logic [5:0] K_STAR = 6'd10;
	localparam logic [5:0] K_BANG = 6'd11;
	localparam logic [5:0] K_EQUAL = 6'd13;
	localparam logic [5:0] K_LESS = 6'd15;
	localparam logic [5:0] K_GREATER = 6'd17;
	localparam logic [5:0] K_HASH = 6'd19;
	localparam logic [5:0] K_SLASH = 6'd20;
	localparam logic [5:0] K_STRING = 6'd21;
	localparam logic [5:0] K_NUMBER = 6'd22;
	localparam logic [5:0] K_IDENT = 6'd23;
	localparam logic [5:0] K_EOF = 6'd35;
	localparam logic [5:0] K_ERR_CHAR = 6'd36;
	localparam logic [5:0] K_ERR_STR = 6'd37;

	localparam logic [KW_MAX*8-1:0] KW_TEXT [NKW] = '{
		"class", "const", "static", "public", "private", "void", "int", "bool",
		"SKCLASS", {"SK_GENERATED", "_BODY"}, "SKPROPERTY", "SKFUNCTION"
	};
	localparam logic [5:0] KW_LEN [NKW] = '{
		6'd5, 6'd5, 6'd6, 6'd6, 6'd7, 6'd4, 6'd3, 6'd4, 6'd7, 6'd17, 6'd10, 6'd10
	};
	localparam logic [5:0] KW_KIND [NKW] = '{
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
		6'd34, 6'd34
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [23:0] start;
		logic [23:0] len;
		logic [23:0] line;
	} tok_t;

	// the tokens caused by one character, at most TOK_SLOTS of them
	typedef struct packed {
		logic [2:0]                 cnt;
		tok_t [TOK_SLOTS-1:0]       tok;
	} bundle_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"], "_"};
	endfunction

	// single-character punctuation; hit low when c is not one of them
	function automatic logic [6:0] single_kind(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		case (c)
			"(": r = {1'b1, K_LPAREN};
			")": r = {1'b1, K_RPAREN};
			"{": r = {1'b1, K_LBRACE};
			"}": r = {1'b1, K_RBRACE};
			",": r = {1'b1, K_COMMA};
			".": r = {1'b1, K_DOT};
			"-": r = {1'b1, K_MINUS};
			"+": r = {1'b1, K_PLUS};
			";": r = {1'b1, K_SEMI};
			":": r = {1'b1, K_COLON};
			"*": r = {1'b1, K_STAR};
			"#": r = {1'b1, K_HASH};
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	// drop keywords whose character at position i differs from c, those too short to have one, and all when ok is low
	function automatic logic [NKW-1:0] narrow(input logic [NKW-1:0] cand,
			input logic [7:0] c, input logic [5:0] i, input logic ok);
		logic [NKW-1:0] r;
		logic [7:0] kc;
		r = cand;
		for (int k = 0; k < NKW; k++) begin
			kc = 8'd0;
			if (i < KW_LEN[k])
				kc = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - int'(i)) +: 8];
			if (!(ok && i < KW_LEN[k] && kc == c))
				r[k] = 1'b0;
		end
		return r;
	endfunction

endpackage

### sv/stsc_in_if.sv
interface stsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_source;

	modport source(output valid, output ch, output end_of_source, input ready);
	modport sink(input valid, input ch, input end_of_source, output ready);
endinterface

### sv/stsc_out_if.sv
interface stsc_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [23:0] start_offset;
	logic [23:0] token_length;
	logic [23:0] line_number;
	logic        last_of_run;

	modport source(output valid, output token_kind, output start_offset,
		output token_length, output line_number, output last_of_run, input ready);
	modport sink(input valid, input token_kind, input start_offset,
		input token_length, input line_number, input last_of_run, output ready);
endinterface

### sv/stsc_front.sv
module stsc_front import stsc_pkg::*; #(
	parameter int OFFSET_BITS = 24,
	parameter int MAX_KEYWORD_LEN = 17
) (
	input  logic       clk,
	input  logic       arst_n,
	stsc_in_if.sink    src,
	input  logic       full,
	output logic       push,
	output bundle_t    push_data
);

	localparam int OB = OFFSET_BITS;
	localparam int CW = (OB > 24) ? OB : 24;
	localparam int KW_IDX_BITS = $clog2(MAX_KEYWORD_LEN + 1);
	localparam int NCAND = 6;

	typedef enum logic [11:0] {
		M_IDLE    = 12'b000000000001,
		M_BANG    = 12'b000000000010,
		M_EQ      = 12'b000000000100,
		M_LESS    = 12'b000000001000,
		M_GREATER = 12'b000000010000,
		M_SLASH   = 12'b000000100000,
		M_COMMENT = 12'b000001000000,
		M_STRING  = 12'b000010000000,
		M_NUM_INT = 12'b000100000000,
		M_NUM_DOT = 12'b001000000000,
		M_NUM_FRAC = 12'b010000000000,
		M_IDENT   = 12'b100000000000
	} mode_t;

	mode_t           mode_q;
	logic [OB-1:0]   start_q;
	logic [OB-1:0]   pos_q;
	logic [OB-1:0]   line_q;
	logic [OB-1:0]   len_q;
	logic [NKW-1:0]  cand_q;

	mode_t           mode_d;
	logic [OB-1:0]   start_d;
	logic [OB-1:0]   pos_d;
	logic [OB-1:0]   line_d;
	logic [OB-1:0]   len_d;
	logic [NKW-1:0]  cand_d;

	logic [NCAND-1:0] cv;
	tok_t             ct [NCAND];
	bundle_t          bun;

	function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] v,
			input logic [OB-1:0] a);
		logic [OB:0] s;
		s = {1'b0, v} + {1'b0, a};
		return s[OB] ? {OB{1'b1}} : s[OB-1:0];
	endfunction

	function automatic logic [23:0] clip(input logic [OB-1:0] v);
		logic [CW-1:0] e;
		e = CW'(v);
		return (e > CW'(OUT_MAX)) ? OUT_MAX : e[23:0];
	endfunction

	function automatic tok_t mk(input logic [5:0] k, input logic [OB-1:0] s,
			input logic [OB-1:0] l, input logic [OB-1:0] ln);
		tok_t t;
		t.kind = k;
		t.start = clip(s);
		t.len = clip(l);
		t.line = clip(ln);
		return t;
	endfunction

	function automatic logic [5:0] ident_kind(input logic [NKW-1:0] cand,
			input logic [OB-1:0] l);
		logic [5:0] r;
		r = K_IDENT;
		for (int k = 0; k < NKW; k++)
			if (cand[k] && l == OB'(KW_LEN[k]))
				r = KW_KIND[k];
		return r;
	endfunction

	function automatic logic [5:0] op_base(input mode_t m);
		logic [5:0] r;
		case (m)
			M_BANG: r = K_BANG;
			M_EQ: r = K_EQUAL;
			M_LESS: r = K_LESS;
			default: r = K_GREATER;
		endcase
		return r;
	endfunction

	// scan one character: held token, fresh dispatch, end-of-source flush
	always_comb begin
		logic [7:0]  c;
		logic        consumed;
		logic [6:0]  sk;
		logic [OB-1:0] one;
		logic [OB-1:0] two;
		logic        kw_ok;
		logic [5:0]  kw_idx;
		c = src.ch;
		one = OB'(1);
		two = OB'(2);
		mode_d = mode_q;
		start_d = start_q;
		line_d = line_q;
		len_d = len_q;
		cand_d = cand_q;
		consumed = 1'b0;
		cv = '0;
		for (int i = 0; i < NCAND; i++)
			ct[i] = '0;
		kw_ok = len_q < OB'(MAX_KEYWORD_LEN);
		kw_idx = 6'(len_q[KW_IDX_BITS-1:0]);

		case (mode_q)
			M_BANG, M_EQ, M_LESS, M_GREATER: begin
				if (c == "=") begin
					cv[0] = 1'b1;
					ct[0] = mk(op_base(mode_q) + 6'd1, start_q, two, line_q);
					consumed = 1'b1;
				end else begin
					cv[0] = 1'b1;
					ct[0] = mk(op_base(mode_q), start_q, one, line_q);
				end
				mode_d = M_IDLE;
			end
			M_SLASH: begin
				if (c == "/") begin
					mode_d = M_COMMENT;
					consumed = 1'b1;
				end else begin
					cv[0] = 1'b1;
					ct[0] = mk(K_SLASH, start_q, one, line_q);
					mode_d = M_IDLE;
				end
			end
			M_COMMENT: begin
				if (c == "\n")
					mode_d = M_IDLE;
				else
					consumed = 1'b1;
			end
			M_STRING: begin
				consumed = 1'b1;
				if (c == "\"") begin
					cv[0] = 1'b1;
					ct[0] = mk(K_STRING, start_q, len_q - one, line_q);
					mode_d = M_IDLE;
				end else begin
					if (c == "\n")
						line_d = sat_add(line_q, one);
					len_d = sat_add(len_q, one);
				end
			end
			M_NUM_INT: begin
				if (is_digit(c)) begin
					len_d = sat_add(len_q, one);
					consumed = 1'b1;
				end else if (c == ".") begin
					mode_d = M_NUM_DOT;
					consumed = 1'b1;
				end else begin
					cv[0] = 1'b1;
					ct[0] = mk(K_NUMBER, start_q, len_q, line_q);
					mode_d = M_IDLE;
				end
			end
			M_NUM_DOT: begin
				if (is_digit(c)) begin
					len_d = sat_add(len_q, two);
					mode_d = M_NUM_FRAC;
					consumed = 1'b1;
				end else begin
					cv[1:0] = 2'b11;
					ct[0] = mk(K_NUMBER, start_q, len_q, line_q);
					ct[1] = mk(K_DOT, sat_add(start_q, len_q), one, line_q);
					mode_d = M_IDLE;
				end
			end
			M_NUM_FRAC: begin
				if (is_digit(c)) begin
					len_d = sat_add(len_q, one);
					consumed = 1'b1;
				end else begin
					cv[0] = 1'b1;
					ct[0] = mk(K_NUMBER, start_q, len_q, line_q);
					mode_d = M_IDLE;
				end
			end
			M_IDENT: begin
				if (is_digit(c) || is_alpha(c)) begin
					cand_d = narrow(cand_q, c, kw_idx, kw_ok);
					len_d = sat_add(len_q, one);
					consumed = 1'b1;
				end else begin
					cv[0] = 1'b1;
					ct[0] = mk(ident_kind(cand_q, len_q), start_q, len_q, line_q);
					mode_d = M_IDLE;
				end
			end
			default: mode_d = M_IDLE;
		endcase

		// start a new lexeme at this character
		if (!consumed) begin
			sk = single_kind(c);
			start_d = pos_q;
			len_d = one;
			if (sk[6]) begin
				cv[2] = 1'b1;
				ct[2] = mk(sk[5:0], pos_q, one, line_d);
			end else begin
				case (c)
					"!": mode_d = M_BANG;
					"=": mode_d = M_EQ;
					"<": mode_d = M_LESS;
					">": mode_d = M_GREATER;
					"/": mode_d = M_SLASH;
					" ", 8'h0D, "\t": mode_d = mode_d;
					"\n": line_d = sat_add(line_d, one);
					"\"": mode_d = M_STRING;
					default: begin
						if (is_digit(c)) begin
							mode_d = M_NUM_INT;
						end else if (is_alpha(c)) begin
							cand_d = narrow({NKW{1'b1}}, c, 6'd0, 1'b1);
							mode_d = M_IDENT;
						end else begin
							cv[2] = 1'b1;
							ct[2] = mk(K_ERR_CHAR, pos_q, one, line_d);
						end
					end
				endcase
			end
		end

		pos_d = sat_add(pos_q, one);

		// close the source: flush the held token and add end-of-file
		if (src.end_of_source) begin
			case (mode_d)
				M_BANG, M_EQ, M_LESS, M_GREATER: begin
					cv[3] = 1'b1;
					ct[3] = mk(op_base(mode_d), start_d, one, line_d);
				end
				M_SLASH: begin
					cv[3] = 1'b1;
					ct[3] = mk(K_SLASH, start_d, one, line_d);
				end
				M_STRING: begin
					cv[3] = 1'b1;
					ct[3] = mk(K_ERR_STR, start_d, len_d - one, line_d);
				end
				M_NUM_INT, M_NUM_FRAC: begin
					cv[3] = 1'b1;
					ct[3] = mk(K_NUMBER, start_d, len_d, line_d);
				end
				M_NUM_DOT: begin
					cv[4:3] = 2'b11;
					ct[3] = mk(K_NUMBER, start_d, len_d, line_d);
					ct[4] = mk(K_DOT, sat_add(start_d, len_d), one, line_d);
				end
				M_IDENT: begin
					cv[3] = 1'b1;
					ct[3] = mk(ident_kind(cand_d, len_d), start_d, len_d, line_d);
				end
				default: cv[3] = 1'b0;
			endcase
			cv[5] = 1'b1;
			ct[5] = mk(K_EOF, pos_d, '0, line_d);
			mode_d = M_IDLE;
			start_d = '0;
			pos_d = '0;
			line_d = one;
			len_d = '0;
			cand_d = {NKW{1'b1}};
		end

		// pack the first four tokens in order
		bun = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cv[i] && bun.cnt < 3'(TOK_SLOTS)) begin
				bun.tok[bun.cnt[1:0]] = ct[i];
				bun.cnt = bun.cnt + 3'd1;
			end
		end
	end

	assign src.ready = !full;
	assign push = src.valid && !full && (bun.cnt != 3'd0);
	assign push_data = bun;

	// advance scanner state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			start_q <= '0;
			pos_q <= '0;
			line_q <= OB'(1);
			len_q <= '0;
			cand_q <= {NKW{1'b1}};
		end else if (src.valid && !full) begin
			mode_q <= mode_d;
			start_q <= start_d;
			pos_q <= pos_d;
			line_q <= line_d;
			len_q <= len_d;
			cand_q <= cand_d;
		end
	end

endmodule

### sv/stsc_queue.sv
module stsc_queue import stsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output logic    full,
	output logic    empty
);

`include "source_token_scanner_top_macros.svh"

	localparam int PW = $clog2(QDEPTH);

	bundle_t          mem_q [QDEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;

	assign full = cnt_q == (PW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_q];

	// store bundles in arrival order
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + PW'(1);
			if (pop)
				rd_q <= rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	`STSC_ASSERT(a_no_push_full, !(push && full), "push into full queue")
	`STSC_ASSERT(a_no_pop_empty, !(pop && empty), "pop from empty queue")
	`STSC_ASSERT(a_cnt_range, cnt_q <= (PW+1)'(QDEPTH), "queue count overflow")
	`STSC_ASSERT_NEXT(a_push_nonempty, push, !empty, "queue empty after push")

endmodule

### sv/stsc_back.sv
module stsc_back import stsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bundle_t    head,
	input  logic       empty,
	output logic       pop,
	stsc_out_if.source dst
);

	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       last;
	logic       load;
	tok_t       tok;

	assign tok = cur_q.tok[idx_q];
	assign last = {1'b0, idx_q} == (cur_q.cnt - 3'd1);
	assign load = !busy_q || (dst.ready && last);
	assign pop = load && !empty;

	assign dst.valid = busy_q;
	assign dst.token_kind = tok.kind;
	assign dst.start_offset = tok.start;
	assign dst.token_length = tok.len;
	assign dst.line_number = tok.line;
	assign dst.last_of_run = last;

	// hold the current bundle; step through its tokens one beat at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b0;
		end else if (dst.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

endmodule

### sv/source_token_scanner_top.sv
// Flow: a token reaches dst through the bundle queue and then the output register cur_q.
// Throughput: one character per cycle while the queue is not full; one token
// beat per cycle out while dst is ready, so the tokens of one character leave one per beat.
// A four-bundle queue between scanner and output lets both sides stall apart.
// Reset (arst_n low): offset 0, line 1, idle scan, queue and output empty.
module source_token_scanner_top import stsc_pkg::*; #(
	parameter int OFFSET_BITS = 24,
	parameter int MAX_KEYWORD_LEN = 17
) (
	input  logic       clk,
	input  logic       arst_n,
	stsc_in_if.sink    src,
	stsc_out_if.source dst
);

	logic    push;
	logic    pop;
	logic    full;
	logic    empty;
	bundle_t push_data;
	bundle_t head;

	stsc_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.src(src),
		.full(full),
		.push(push),
		.push_data(push_data)
	);

	stsc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	stsc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.dst(dst)
	);

endmodule

### verif/tb_source_token_scanner_top.sv
module tb_source_token_scanner_top;
	import stsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP = 32'h00FF_FFFF;

	typedef enum logic [3:0] {
		S_IDLE, S_BANG, S_EQ, S_LESS, S_GREATER, S_SLASH, S_COMMENT,
		S_STRING, S_INT, S_DOT, S_FRAC, S_WORD
	} scan_state_e;

	typedef struct {
		logic [5:0]  kind;
		logic [23:0] start;
		logic [23:0] len;
		logic [23:0] line;
		logic        last;
	} token_t;

	typedef struct {
		logic [7:0] c;
		logic       eos;
	} src_byte_t;

	// directed row: when typed, the single token expected is given here
	typedef struct {
		logic [7:0]  c;
		logic        eos;
		logic        typed;
		logic [5:0]  kind;
		logic [23:0] start;
		logic [23:0] len;
		logic [23:0] line;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stsc_in_if  chars ();
	stsc_out_if tokens ();

	source_token_scanner_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (chars),
		.dst    (tokens)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// scanner shadow state
	scan_state_e  st;
	int unsigned  tok_start, at_pos, line_no, lex_n;
	logic [11:0]  kw_live;
	token_t       step_toks[$];
	token_t       pending_tokens[$];

	int errors = 0;
	int chars_sent = 0;
	int tokens_seen = 0;
	int sources_closed = 0;
	int sink_stall = 0;
	bit took_beat = 1'b0;
	bit no_idle = 1'b0;

	function automatic int unsigned bump(int unsigned v, int unsigned a);
		return (v >= CAP || CAP - v < a) ? CAP : v + a;
	endfunction

	function automatic logic [23:0] clip(int unsigned v);
		return (v > CAP) ? 24'hFFFFFF : v[23:0];
	endfunction

	function automatic bit digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [7:0] kw_char(int k, int i);
		return KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8];
	endfunction

	function void emit(logic [5:0] kind, int unsigned s, int unsigned n);
		token_t t;
		if (step_toks.size() >= 4)
			return;
		t.kind = kind;
		t.start = clip(s);
		t.len = clip(n);
		t.line = clip(line_no);
		t.last = 1'b0;
		step_toks.insert(step_toks.size(), t);
	endfunction

	function void reset_scan();
		st = S_IDLE;
		tok_start = 0;
		at_pos = 0;
		line_no = 1;
		kw_live = '1;
		lex_n = 0;
	endfunction

	function void narrow_kw(logic [7:0] c, int unsigned idx);
		for (int k = 0; k < NKW; k++) begin
			if (idx >= KW_LEN[k] || kw_char(k, idx) != c)
				kw_live[k] = 1'b0;
		end
	endfunction

	function void emit_word();
		logic [5:0] kind;
		kind = K_IDENT;
		for (int k = 0; k < NKW; k++)
			if (kw_live[k] && lex_n == KW_LEN[k])
				kind = KW_KIND[k];
		emit(kind, tok_start, lex_n);
	endfunction

	function automatic logic [5:0] op_kind(scan_state_e s);
		case (s)
			S_BANG:  return K_BANG;
			S_EQ:    return K_EQUAL;
			S_LESS:  return K_LESS;
			default: return K_GREATER;
		endcase
	endfunction

	function automatic logic [6:0] punct(logic [7:0] c);
		case (c)
			"(": return {1'b1, K_LPAREN};
			")": return {1'b1, K_RPAREN};
			"{": return {1'b1, K_LBRACE};
			"}": return {1'b1, K_RBRACE};
			",": return {1'b1, K_COMMA};
			".": return {1'b1, K_DOT};
			"-": return {1'b1, K_MINUS};
			"+": return {1'b1, K_PLUS};
			";": return {1'b1, K_SEMI};
			":": return {1'b1, K_COLON};
			"*": return {1'b1, K_STAR};
			"#": return {1'b1, K_HASH};
			default: return 7'd0;
		endcase
	endfunction

	// start a new lexeme on c
	function void start_lexeme(logic [7:0] c, int unsigned pos);
		logic [6:0] p;
		p = punct(c);
		tok_start = pos;
		lex_n = 1;
		if (p[6]) begin
			emit(p[5:0], pos, 1);
			return;
		end
		case (c)
			"!": st = S_BANG;
			"=": st = S_EQ;
			"<": st = S_LESS;
			">": st = S_GREATER;
			"/": st = S_SLASH;
			" ", 8'h0D, 8'h09: ;
			8'h0A: line_no = bump(line_no, 1);
			"\"": st = S_STRING;
			default: begin
				if (digit(c)) begin
					st = S_INT;
				end else if (letter(c)) begin
					kw_live = '1;
					narrow_kw(c, 0);
					st = S_WORD;
				end else begin
					emit(K_ERR_CHAR, pos, 1);
				end
			end
		endcase
	endfunction

	// feed c to the held lexeme; return 1 if it was absorbed
	function bit extend_lexeme(logic [7:0] c);
		case (st)
			S_BANG, S_EQ, S_LESS, S_GREATER: begin
				if (c == "=") begin
					emit(op_kind(st) + 6'd1, tok_start, 2);
					st = S_IDLE;
					return 1'b1;
				end
				emit(op_kind(st), tok_start, 1);
				st = S_IDLE;
				return 1'b0;
			end
			S_SLASH: begin
				if (c == "/") begin
					st = S_COMMENT;
					return 1'b1;
				end
				emit(K_SLASH, tok_start, 1);
				st = S_IDLE;
				return 1'b0;
			end
			S_COMMENT: begin
				if (c == 8'h0A) begin
					st = S_IDLE;
					return 1'b0;
				end
				return 1'b1;
			end
			S_STRING: begin
				if (c == "\"") begin
					emit(K_STRING, tok_start, lex_n - 1);
					st = S_IDLE;
					return 1'b1;
				end
				if (c == 8'h0A)
					line_no = bump(line_no, 1);
				lex_n = bump(lex_n, 1);
				return 1'b1;
			end
			S_INT: begin
				if (digit(c)) begin
					lex_n = bump(lex_n, 1);
					return 1'b1;
				end
				if (c == ".") begin
					st = S_DOT;
					return 1'b1;
				end
				emit(K_NUMBER, tok_start, lex_n);
				st = S_IDLE;
				return 1'b0;
			end
			S_DOT: begin
				if (digit(c)) begin
					lex_n = bump(lex_n, 2);
					st = S_FRAC;
					return 1'b1;
				end
				emit(K_NUMBER, tok_start, lex_n);
				emit(K_DOT, bump(tok_start, lex_n), 1);
				st = S_IDLE;
				return 1'b0;
			end
			S_FRAC: begin
				if (digit(c)) begin
					lex_n = bump(lex_n, 1);
					return 1'b1;
				end
				emit(K_NUMBER, tok_start, lex_n);
				st = S_IDLE;
				return 1'b0;
			end
			S_WORD: begin
				if (digit(c) || letter(c)) begin
					narrow_kw(c, lex_n);
					lex_n = bump(lex_n, 1);
					return 1'b1;
				end
				emit_word();
				st = S_IDLE;
				return 1'b0;
			end
			default: begin
				st = S_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	// close any open lexeme at the end of the source
	function void flush_source();
		case (st)
			S_BANG, S_EQ, S_LESS, S_GREATER: emit(op_kind(st), tok_start, 1);
			S_SLASH: emit(K_SLASH, tok_start, 1);
			S_STRING: emit(K_ERR_STR, tok_start, lex_n - 1);
			S_INT, S_FRAC: emit(K_NUMBER, tok_start, lex_n);
			S_DOT: begin
				emit(K_NUMBER, tok_start, lex_n);
				emit(K_DOT, bump(tok_start, lex_n), 1);
			end
			S_WORD: emit_word();
			default: ;
		endcase
		st = S_IDLE;
	endfunction

	// compute the tokens caused by one character into step_toks
	function void scan_char(logic [7:0] c, logic eos);
		int unsigned pos;
		pos = at_pos;
		step_toks.delete();
		if (!extend_lexeme(c))
			start_lexeme(c, pos);
		at_pos = bump(at_pos, 1);
		if (eos) begin
			flush_source();
			emit(K_EOF, at_pos, 0);
			reset_scan();
		end
		if (step_toks.size() > 0)
			step_toks[$].last = 1'b1;
	endfunction

	// drive one beat; typed rows queue their own expectation
	task automatic send_char(logic [7:0] c, logic eos, bit typed, token_t typed_tok);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			chars.valid = 1'b0;
		end
		@(negedge clk);
		chars.valid = 1'b1;
		chars.ch = c;
		chars.end_of_source = eos;
		do @(posedge clk); while (!chars.ready);
		scan_char(c, eos);
		if (typed)
			pending_tokens.insert(pending_tokens.size(), typed_tok);
		else
			foreach (step_toks[i]) pending_tokens.insert(pending_tokens.size(), step_toks[i]);
		chars_sent++;
		if (eos)
			sources_closed++;
	endtask

	// draw a random stall after each beat, then hold ready low until it has counted down
	always @(negedge clk) begin
		if (took_beat)
			sink_stall = no_idle ? 0 : $urandom_range(0, 10);
		if (sink_stall > 0) begin
			tokens.ready = 1'b0;
			sink_stall--;
		end else begin
			tokens.ready = 1'b1;
		end
	end

	// compare each token beat with the oldest expectation
	always @(posedge clk) begin
		token_t e;
		took_beat = arst_n && tokens.valid && tokens.ready;
		if (took_beat) begin
			tokens_seen++;
			if (pending_tokens.size() == 0) begin
				$error("unexpected token kind %0d", tokens.token_kind);
				errors++;
			end else begin
				e = pending_tokens.pop_front();
				if (tokens.token_kind !== e.kind) begin
					$error("token_kind exp %0d got %0d", e.kind, tokens.token_kind);
					errors++;
				end
				if (tokens.start_offset !== e.start) begin
					$error("start_offset exp %0d got %0d", e.start, tokens.start_offset);
					errors++;
				end
				if (tokens.token_length !== e.len) begin
					$error("token_length exp %0d got %0d", e.len, tokens.token_length);
					errors++;
				end
				if (tokens.line_number !== e.line) begin
					$error("line_number exp %0d got %0d", e.line, tokens.line_number);
					errors++;
				end
				if (tokens.last_of_run !== e.last) begin
					$error("last_of_run exp %0d got %0d", e.last, tokens.last_of_run);
					errors++;
				end
			end
		end
	end

	src_byte_t stream[$];

	function automatic void add_byte(logic [7:0] c);
		src_byte_t b;
		b.c = c;
		b.eos = 1'b0;
		stream.insert(stream.size(), b);
	endfunction

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		return "_";
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(0, 4) == 0) ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
	endfunction

	// build one random fragment of plausible source text
	task automatic add_fragment();
		int k, n;
		string ops[$] = '{"!=", "==", "<=", ">=", "!", "=", "<", ">", "/", "(", ")",
			"{", "}", ",", ".", "-", "+", ";", ":", "*", "#"};
		case ($urandom_range(0, 11))
			0, 1: begin
				// keyword, sometimes extended or cut short
				k = $urandom_range(0, NKW - 1);
				n = int'(KW_LEN[k]);
				if ($urandom_range(0, 3) == 0)
					n = $urandom_range(1, n);
				for (int i = 0; i < n; i++)
					add_byte(kw_char(k, i));
				if ($urandom_range(0, 3) == 0)
					add_byte(rand_alnum());
			end
			2: begin
				add_byte(rand_letter());
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 6);
				repeat (n) add_byte(rand_alnum());
			end
			3: begin
				repeat ($urandom_range(1, 4)) add_byte(8'("0" + $urandom_range(0, 9)));
				if ($urandom_range(0, 1)) begin
					add_byte(".");
					repeat ($urandom_range(0, 3))
						add_byte(8'("0" + $urandom_range(0, 9)));
				end
			end
			4: begin
				add_byte("\"");
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 4) == 0)
						add_byte(8'h0A);
					else
						add_byte(rand_alnum());
				end
				if ($urandom_range(0, 5) != 0)
					add_byte("\"");
			end
			5, 6: add_text(ops[$urandom_range(0, ops.size() - 1)]);
			7: begin
				add_text("//");
				repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 3) != 0)
					add_byte(8'h0A);
			end
			8, 9: begin
				case ($urandom_range(0, 3))
					0: add_byte(" ");
					1: add_byte(8'h09);
					2: add_byte(8'h0D);
					default: add_byte(8'h0A);
				endcase
			end
			10: add_byte(" ");
			default: add_byte(8'($urandom_range(0, 255)));
		endcase
		// close the source now and then
		if ($urandom_range(0, 14) == 0)
			stream[$].eos = 1'b1;
	endtask

	row_t directed[] = '{
		'{8'h80, 1'b0, 1'b1, K_ERR_CHAR, 24'd0, 24'd1, 24'd1},
		'{8'h00, 1'b0, 1'b1, K_ERR_CHAR, 24'd1, 24'd1, 24'd1},
		'{8'hFF, 1'b0, 1'b1, K_ERR_CHAR, 24'd2, 24'd1, 24'd1},
		'{"!", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"=", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"<", 1'b0, 1'b0, 0, 0, 0, 0},
		'{">", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"=", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"=", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"/", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"/", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"x", 1'b0, 1'b0, 0, 0, 0, 0},
		'{8'h0A, 1'b0, 1'b0, 0, 0, 0, 0},
		'{"\"", 1'b0, 1'b0, 0, 0, 0, 0},
		'{8'h0A, 1'b0, 1'b0, 0, 0, 0, 0},
		'{"\"", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"7", 1'b0, 1'b0, 0, 0, 0, 0},
		'{".", 1'b0, 1'b0, 0, 0, 0, 0},
		'{";", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"\"", 1'b0, 1'b0, 0, 0, 0, 0},
		'{"q", 1'b1, 1'b0, 0, 0, 0, 0},
		'{" ", 1'b1, 1'b1, K_EOF, 24'd1, 24'd0, 24'd1},
		'{"9", 1'b0, 1'b0, 0, 0, 0, 0},
		'{".", 1'b1, 1'b0, 0, 0, 0, 0},
		'{"/", 1'b1, 1'b0, 0, 0, 0, 0}
	};

	initial begin
		token_t t;
		chars.valid = 1'b0;
		chars.ch = 8'h00;
		chars.end_of_source = 1'b0;
		reset_scan();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (directed[i]) begin
			t = '{directed[i].kind, directed[i].start, directed[i].len, directed[i].line, 1'b1};
			send_char(directed[i].c, directed[i].eos, directed[i].typed, t);
		end

		// hold the sender until all tokens so far have drained
		@(negedge clk);
		chars.valid = 1'b0;
		wait (pending_tokens.size() == 0);
		repeat (4) @(posedge clk);

		// random sources, with bursts of no idling on both sides
		while (stream.size() < 400)
			add_fragment();
		stream[$].eos = 1'b1;
		foreach (stream[i]) begin
			if (i % 60 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			send_char(stream[i].c, stream[i].eos, 1'b0, t);
		end
		@(negedge clk);
		chars.valid = 1'b0;
		no_idle = 1'b0;

		wait (pending_tokens.size() == 0);
		repeat (20) @(posedge clk);
		$display("Scanned %0d characters over %0d sources into %0d tokens.",
			chars_sent, sources_closed, tokens_seen);
		$display("Random source text mixed keywords, operators, strings, numbers and noise.");
		if (errors == 0)
			$display("tb_source_token_scanner_top: PASS");
		else
			$display("tb_source_token_scanner_top: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#4ms;
		$display("tb_source_token_scanner_top: FAIL");
		$finish;
	end

endmodule
